### rtl/seven_segment_mux_with_key_scan_macros.svh
// Assertion macros for the seven-segment scanner; empty when SYNTH is defined.
`ifndef SEVEN_SEGMENT_MUX_WITH_KEY_SCAN_MACROS_SVH
`define SEVEN_SEGMENT_MUX_WITH_KEY_SCAN_MACROS_SVH

`ifndef SYNTH

// Antecedent implies the consequent in the same cycle.
`define SSMKS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies the consequent in the following cycle.
`define SSMKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define SSMKS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SSMKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/ssmks_pkg.sv
// Shared types and constants for the seven-segment scanner with key sense.
package ssmks_pkg;

    localparam int SEG_W    = 8;
    localparam int DRV_W    = 5;
    localparam int SLOT_W   = 3;
    localparam int PHASE_W  = 5;
    localparam int DIV_W    = 8;
    localparam int KEY_N    = 3;
    localparam int SLOT_N   = 5;

    localparam logic [DIV_W-1:0]   DIVIDER_RESET = 8'd20;
    localparam logic [PHASE_W-1:0] PHASE_LAST    = 5'd19;
    localparam logic [DRV_W-1:0]   DRIVERS_OFF   = 5'h1F;
    localparam logic [SEG_W-1:0]   SEGMENTS_OFF  = 8'hFF;
    localparam logic [SLOT_W-1:0]  SLOT_COUNT    = 3'd5;

    // Item kinds carried in tuser.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Pattern slots.
    localparam int SLOT_DIGIT1 = 0;
    localparam int SLOT_DIGIT2 = 1;
    localparam int SLOT_DIGIT3 = 2;
    localparam int SLOT_DIGIT4 = 3;
    localparam int SLOT_MISC   = 4;

    // Driver bit positions.
    localparam int DRV_DIGIT4 = 0;
    localparam int DRV_DIGIT3 = 1;
    localparam int DRV_MISC   = 2;
    localparam int DRV_DIGIT2 = 3;
    localparam int DRV_DIGIT1 = 4;

    // Phases that act; every other phase does nothing.
    localparam logic [PHASE_W-1:0] PH_SHOW_DIGIT4 = 5'd0;
    localparam logic [PHASE_W-1:0] PH_KEY_ONE     = 5'd1;
    localparam logic [PHASE_W-1:0] PH_OFF_A       = 5'd3;
    localparam logic [PHASE_W-1:0] PH_SHOW_DIGIT3 = 5'd4;
    localparam logic [PHASE_W-1:0] PH_KEY_TWO     = 5'd5;
    localparam logic [PHASE_W-1:0] PH_OFF_B       = 5'd7;
    localparam logic [PHASE_W-1:0] PH_SHOW_MISC   = 5'd8;
    localparam logic [PHASE_W-1:0] PH_KEY_THREE   = 5'd9;
    localparam logic [PHASE_W-1:0] PH_OFF_C       = 5'd11;
    localparam logic [PHASE_W-1:0] PH_SHOW_DIGIT2 = 5'd12;
    localparam logic [PHASE_W-1:0] PH_OFF_D       = 5'd15;
    localparam logic [PHASE_W-1:0] PH_SHOW_DIGIT1 = 5'd16;
    localparam logic [PHASE_W-1:0] PH_OFF_E       = 5'd19;

    // One input transaction.
    typedef struct packed {
        logic              kind;
        logic              sense_line;
        logic [SEG_W-1:0]  pattern;
        logic [SLOT_W-1:0] slot;
    } item_t;

    // One result transaction, last field in the lowest bits.
    typedef struct packed {
        logic             key_three;
        logic             key_two;
        logic             key_one;
        logic [DRV_W-1:0] driver_bits;
        logic [SEG_W-1:0] segment_bits;
    } result_t;

endpackage

### rtl/seven_segment_mux_with_key_scan.sv
// Top level of the multiplexed seven-segment scanner with shared-line key sense.

// Streaming front end for a five-position common-anode display scanner. Each input
// transaction is either a timer tick (tuser low) or a pattern write (tuser high);
// every transaction returns exactly one result transaction carrying the segment
// port, the active-low drivers and the three latched keys as they stand after it.
// A transaction is registered on entry and processed by the scanner state as it
// moves on, and its result is placed in the output register; one transaction is
// taken every cycle while the output side keeps up; the limit is the update of the
// prescaler, phase counter and pattern slots, done once per transaction. A
// phase step happens every tick_divider + 1 ticks; cfg_data written with cfg_we
// sets tick_divider and should only be written while no transaction is in flight.
module seven_segment_mux_with_key_scan
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ssmks_pkg::DIV_W-1:0]   cfg_data,      // tick_divider
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // slot, pattern, sense_line, zero pad
    input  logic                          s_axis_tuser,  // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata   // segment_bits, driver_bits,
                                                         // key_one, key_two, key_three
);

    `include "seven_segment_mux_with_key_scan_macros.svh"

    logic               in_valid_reg;
    logic               in_valid_next;
    ssmks_pkg::item_t   in_item_reg;
    ssmks_pkg::item_t   in_item;
    logic               out_valid_reg;
    logic               out_valid_next;
    ssmks_pkg::result_t out_result_reg;
    ssmks_pkg::result_t scan_result;
    logic               advance;
    logic               s_accept;

    // Unpack the incoming transaction.
    assign in_item.kind       = s_axis_tuser;
    assign in_item.sense_line = s_axis_tdata[11];
    assign in_item.pattern    = s_axis_tdata[10:3];
    assign in_item.slot       = s_axis_tdata[2:0];

    // Handshake: the held transaction moves on when the output register is free.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Scanner state update.
    ssmks_scan u_scan
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .step     (advance),
        .item     (in_item_reg),
        .result   (scan_result)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_result_reg <= scan_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_result_reg;

    // At most one position driver is pulled low in any result.
    `SSMKS_ASSERT_NOW(a_one_driver, clk, rst_n, out_valid_reg, $onehot0(~out_result_reg.driver_bits))
    // A held transaction that cannot move is kept.
    `SSMKS_ASSERT_NEXT(a_hold_item, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    // No new transaction is taken while the held one is stuck.
    `SSMKS_ASSERT_NOW(a_no_overrun, clk, rst_n, in_valid_reg && !advance, !s_axis_tready)
    // A transaction that moves on shows up as a result.
    `SSMKS_ASSERT_NEXT(a_result_out, clk, rst_n, advance, out_valid_reg)

endmodule

### rtl/ssmks_scan.sv
// Scanner state: prescaler, phase counter, pattern slots, outputs and key latches.
module ssmks_scan
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ssmks_pkg::DIV_W-1:0]    cfg_data,
    input  logic                           step,
    input  ssmks_pkg::item_t               item,
    output ssmks_pkg::result_t             result
);

    logic [ssmks_pkg::DIV_W-1:0]   divider_reg;
    logic [ssmks_pkg::DIV_W-1:0]   prescale_reg;
    logic [ssmks_pkg::DIV_W-1:0]   prescale_next;
    logic [ssmks_pkg::PHASE_W-1:0] phase_reg;
    logic [ssmks_pkg::PHASE_W-1:0] phase_next;
    logic [ssmks_pkg::SEG_W-1:0]   pattern_reg  [ssmks_pkg::SLOT_N];
    logic [ssmks_pkg::SEG_W-1:0]   pattern_next [ssmks_pkg::SLOT_N];
    logic [ssmks_pkg::SEG_W-1:0]   segment_reg;
    logic [ssmks_pkg::SEG_W-1:0]   segment_next;
    logic [ssmks_pkg::DRV_W-1:0]   driver_reg;
    logic [ssmks_pkg::DRV_W-1:0]   driver_next;
    logic [ssmks_pkg::KEY_N-1:0]   key_reg;
    logic [ssmks_pkg::KEY_N-1:0]   key_next;
    logic                          pressed;
    logic                          tick;
    logic                          wrap;

    assign pressed = (item.sense_line == 1'b0);
    assign tick    = step && (item.kind == ssmks_pkg::KIND_TICK);
    assign wrap    = !(prescale_reg < divider_reg);

    // Pattern slot writes; slots beyond the last are ignored.
    always_comb
    begin
        for (int i = 0; i < ssmks_pkg::SLOT_N; i++)
        begin
            pattern_next[i] = pattern_reg[i];
            if (step && (item.kind == ssmks_pkg::KIND_WRITE) &&
                (item.slot < ssmks_pkg::SLOT_COUNT) &&
                (item.slot == ssmks_pkg::SLOT_W'(i)))
            begin
                pattern_next[i] = item.pattern;
            end
        end
    end

    // Prescaler and phase actions for a tick.
    always_comb
    begin
        prescale_next = prescale_reg;
        phase_next    = phase_reg;
        segment_next  = segment_reg;
        driver_next   = driver_reg;
        key_next      = key_reg;
        if (tick)
        begin
            if (!wrap)
            begin
                prescale_next = prescale_reg + 1'b1;
            end
            else
            begin
                prescale_next = '0;
                case (phase_reg)
                    ssmks_pkg::PH_SHOW_DIGIT4:
                    begin
                        segment_next = pattern_reg[ssmks_pkg::SLOT_DIGIT4];
                        driver_next[ssmks_pkg::DRV_DIGIT4] = 1'b0;
                    end
                    ssmks_pkg::PH_SHOW_DIGIT3:
                    begin
                        segment_next = pattern_reg[ssmks_pkg::SLOT_DIGIT3];
                        driver_next[ssmks_pkg::DRV_DIGIT3] = 1'b0;
                    end
                    ssmks_pkg::PH_SHOW_MISC:
                    begin
                        segment_next = pattern_reg[ssmks_pkg::SLOT_MISC];
                        driver_next[ssmks_pkg::DRV_MISC] = 1'b0;
                    end
                    ssmks_pkg::PH_SHOW_DIGIT2:
                    begin
                        segment_next = pattern_reg[ssmks_pkg::SLOT_DIGIT2];
                        driver_next[ssmks_pkg::DRV_DIGIT2] = 1'b0;
                    end
                    ssmks_pkg::PH_SHOW_DIGIT1:
                    begin
                        segment_next = pattern_reg[ssmks_pkg::SLOT_DIGIT1];
                        driver_next[ssmks_pkg::DRV_DIGIT1] = 1'b0;
                    end
                    ssmks_pkg::PH_KEY_ONE:
                    begin
                        key_next[0] = pressed;
                    end
                    ssmks_pkg::PH_KEY_TWO:
                    begin
                        key_next[1] = pressed;
                    end
                    ssmks_pkg::PH_KEY_THREE:
                    begin
                        key_next[2] = pressed;
                    end
                    ssmks_pkg::PH_OFF_A, ssmks_pkg::PH_OFF_B, ssmks_pkg::PH_OFF_C,
                    ssmks_pkg::PH_OFF_D, ssmks_pkg::PH_OFF_E:
                    begin
                        driver_next = ssmks_pkg::DRIVERS_OFF;
                    end
                    default:
                    begin
                    end
                endcase
                if (phase_reg >= ssmks_pkg::PHASE_LAST)
                begin
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg  <= ssmks_pkg::DIVIDER_RESET;
            prescale_reg <= '0;
            phase_reg    <= '0;
            segment_reg  <= ssmks_pkg::SEGMENTS_OFF;
            driver_reg   <= ssmks_pkg::DRIVERS_OFF;
            key_reg      <= '0;
            for (int i = 0; i < ssmks_pkg::SLOT_N; i++)
            begin
                pattern_reg[i] <= ssmks_pkg::SEGMENTS_OFF;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                divider_reg <= cfg_data;
            end
            prescale_reg <= prescale_next;
            phase_reg    <= phase_next;
            segment_reg  <= segment_next;
            driver_reg   <= driver_next;
            key_reg      <= key_next;
            for (int i = 0; i < ssmks_pkg::SLOT_N; i++)
            begin
                pattern_reg[i] <= pattern_next[i];
            end
        end
    end

    // The result reflects the state after the item.
    assign result.segment_bits = segment_next;
    assign result.driver_bits  = driver_next;
    assign result.key_one      = key_next[0];
    assign result.key_two      = key_next[1];
    assign result.key_three    = key_next[2];

endmodule

### tb/testbench.sv
// Self-checking stream testbench for the seven-segment scanner with key sense.
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SEGMENT_ITEMS = 175;
    localparam int DRAIN_CYCLES  = 4;

    // Predicts the display scanner state and holds the expected output transactions.
    class scan_scoreboard;
        logic [ssmks_pkg::DIV_W-1:0]   divider;
        logic [ssmks_pkg::DIV_W-1:0]   prescale;
        logic [ssmks_pkg::PHASE_W-1:0] phase;
        logic [ssmks_pkg::SEG_W-1:0]   store [ssmks_pkg::SLOT_N];
        logic [ssmks_pkg::SEG_W-1:0]   segments;
        logic [ssmks_pkg::DRV_W-1:0]   drivers;
        logic [ssmks_pkg::KEY_N-1:0]   keys;
        ssmks_pkg::result_t            expected_outputs [$];
        int                            failures;

        function new();
            divider  = ssmks_pkg::DIVIDER_RESET;
            prescale = '0;
            phase    = '0;
            for (int i = 0; i < ssmks_pkg::SLOT_N; i++)
            begin
                store[i] = ssmks_pkg::SEGMENTS_OFF;
            end
            segments = ssmks_pkg::SEGMENTS_OFF;
            drivers  = ssmks_pkg::DRIVERS_OFF;
            keys     = '0;
            failures = 0;
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        // Load one slot onto the segment port and pull its driver low.
        function void show_slot(int slot_idx, int drv_bit);
            segments         = store[slot_idx];
            drivers[drv_bit] = 1'b0;
        endfunction

        // Carry out the action of the current phase, then advance the phase.
        function void step_phase(logic pressed);
            case (phase)
                ssmks_pkg::PH_SHOW_DIGIT4:
                    show_slot(ssmks_pkg::SLOT_DIGIT4, ssmks_pkg::DRV_DIGIT4);
                ssmks_pkg::PH_KEY_ONE:     keys[0] = pressed;
                ssmks_pkg::PH_SHOW_DIGIT3:
                    show_slot(ssmks_pkg::SLOT_DIGIT3, ssmks_pkg::DRV_DIGIT3);
                ssmks_pkg::PH_KEY_TWO:     keys[1] = pressed;
                ssmks_pkg::PH_SHOW_MISC:
                    show_slot(ssmks_pkg::SLOT_MISC, ssmks_pkg::DRV_MISC);
                ssmks_pkg::PH_KEY_THREE:   keys[2] = pressed;
                ssmks_pkg::PH_SHOW_DIGIT2:
                    show_slot(ssmks_pkg::SLOT_DIGIT2, ssmks_pkg::DRV_DIGIT2);
                ssmks_pkg::PH_SHOW_DIGIT1:
                    show_slot(ssmks_pkg::SLOT_DIGIT1, ssmks_pkg::DRV_DIGIT1);
                ssmks_pkg::PH_OFF_A, ssmks_pkg::PH_OFF_B, ssmks_pkg::PH_OFF_C,
                ssmks_pkg::PH_OFF_D, ssmks_pkg::PH_OFF_E:
                    drivers = ssmks_pkg::DRIVERS_OFF;
                default: ;
            endcase
            phase = (phase == ssmks_pkg::PHASE_LAST) ? '0 : phase + 1'b1;
        endfunction

        // Apply one accepted input transaction and queue the output it causes.
        function void note_item(logic kind, logic [ssmks_pkg::SLOT_W-1:0] slot,
                                logic [ssmks_pkg::SEG_W-1:0] pattern, logic sense);
            ssmks_pkg::result_t res;
            if (kind == ssmks_pkg::KIND_WRITE)
            begin
                if (slot < ssmks_pkg::SLOT_COUNT)
                    store[slot] = pattern;
            end
            else if (prescale < divider)
            begin
                prescale = prescale + 1'b1;
            end
            else
            begin
                // Also covers a divider lowered below the running count.
                prescale = '0;
                step_phase(!sense);
            end
            res.segment_bits = segments;
            res.driver_bits  = drivers;
            res.key_one      = keys[0];
            res.key_two      = keys[1];
            res.key_three    = keys[2];
            expected_outputs.push_back(res);
        endfunction

        function void compare_field(string name, int expected, int actual);
            if (expected != actual)
            begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expected, actual);
                failures++;
            end
        endfunction

        // Compare one output transaction with the oldest expectation.
        function void check_output(logic [15:0] data);
            ssmks_pkg::result_t got;
            ssmks_pkg::result_t exp;
            got = data;
            if (expected_outputs.size() == 0)
            begin
                $error("output transaction 0x%04h arrived with nothing expected", data);
                failures++;
                return;
            end
            exp = expected_outputs.pop_front();
            compare_field("segment_bits", exp.segment_bits, got.segment_bits);
            compare_field("driver_bits", exp.driver_bits, got.driver_bits);
            compare_field("key_one", exp.key_one, got.key_one);
            compare_field("key_two", exp.key_two, got.key_two);
            compare_field("key_three", exp.key_three, got.key_three);
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [ssmks_pkg::DIV_W-1:0]   cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [15:0]                   s_axis_tdata;   // slot, pattern, sense_line, zero pad
    logic                          s_axis_tuser;   // kind
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [15:0]                   m_axis_tdata;   // segment_bits, driver_bits, key_one,
                                                   // key_two, key_three

    scan_scoreboard     sb;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 cycle_count = 0;

    seven_segment_mux_with_key_scan dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: random back-pressure and checking of every output transaction.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_output(m_axis_tdata);
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("seven_segment_mux_with_key_scan test failed");
            $finish;
        end
    end

    // Offer one input transaction after a random gap and wait for its acceptance.
    task automatic send_item(logic kind, logic [ssmks_pkg::SLOT_W-1:0] slot,
                             logic [ssmks_pkg::SEG_W-1:0] pattern, logic sense);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0000, sense, pattern, slot};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(kind, slot, pattern, sense);
    endtask

    // Block until every expected output transaction has arrived.
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Write the tick divider while the block is idle.
    task automatic write_divider(logic [ssmks_pkg::DIV_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        sb.divider  = value;
    endtask

    // Random mix: mostly ticks, some writes, a few writes to slots out of range.
    task automatic send_random_items(int count);
        logic                          kind;
        logic [ssmks_pkg::SLOT_W-1:0]  slot;
        for (int i = 0; i < count; i++)
        begin
            kind = ($urandom_range(99) < 25) ? ssmks_pkg::KIND_WRITE : ssmks_pkg::KIND_TICK;
            slot = ($urandom_range(9) == 0) ? ssmks_pkg::SLOT_W'($urandom_range(7, 5))
                                            : ssmks_pkg::SLOT_W'($urandom_range(4));
            send_item(kind, slot, ssmks_pkg::SEG_W'($urandom_range(255)),
                      1'($urandom_range(1)));
        end
    endtask

    // Main sequence.
    initial
    begin
        logic [ssmks_pkg::DIV_W-1:0] seg_divider [6];
        logic [ssmks_pkg::SEG_W-1:0] slot_pattern [ssmks_pkg::SLOT_N];

        sb            = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ssmks_pkg::KIND_TICK;
        send_idle_pct = 6;
        recv_idle_pct = 46;

        seg_divider  = '{8'd255, 8'd3, 8'd0, 8'd1, 8'd9, 8'd0};
        seg_divider[5] = ssmks_pkg::DIV_W'($urandom_range(255));
        slot_pattern = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h81};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: every tick steps a phase with the divider at zero.
        write_divider(8'd0);
        for (int i = 0; i < ssmks_pkg::SLOT_N; i++)
            send_item(ssmks_pkg::KIND_WRITE, ssmks_pkg::SLOT_W'(i), slot_pattern[i], 1'b1);
        // Writes to slots out of range are dropped.
        send_item(ssmks_pkg::KIND_WRITE, 3'd5, 8'h00, 1'b0);
        send_item(ssmks_pkg::KIND_WRITE, 3'd7, 8'h00, 1'b1);
        // One full phase cycle with every button pressed.
        for (int i = 0; i < 20; i++)
            send_item(ssmks_pkg::KIND_TICK, 3'd0, 8'h00, 1'b0);

        // Random segments; a large divider followed by a small one lowers it below
        // the running count.
        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 6;
                    recv_idle_pct = 46;
                end
                1:
                begin
                    send_idle_pct = 46;
                    recv_idle_pct = 6;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_divider(seg_divider[seg]);
            send_random_items(SEGMENT_ITEMS);
        end
        s_axis_tvalid <= 1'b0;

        // Drain and finish.
        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("seven_segment_mux_with_key_scan test passed");
        else
            $display("seven_segment_mux_with_key_scan test failed");
        $finish;
    end

endmodule
